[hw/rtl/fmis_pkg.sv]
// Shared request/result types and operation codes for the first-match index search.
package fmis_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned LIST_W  = 2;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned INDEX_W = 31;
  // Stored word: valid flag on top of the node index
  localparam int unsigned WORD_W  = INDEX_W + 1;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [LIST_W-1:0]  list_number;
    logic [POS_W-1:0]   list_position;
    logic [INDEX_W-1:0] node_index;
  } req_t;

  typedef struct packed {
    logic [LIST_W-1:0] recv_list;
    logic [POS_W-1:0]  recv_position;
    logic [LIST_W-1:0] send_list;
    logic [POS_W-1:0]  send_position;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic start;       // latch request, rewind the address counter
    logic load;        // write one entry (datapath checks range)
    logic clear_step;  // invalidate entry at counter, advance
    logic scan_step;   // read entry at counter, advance
    logic capture;     // latch match coordinates
    logic push;        // move match into the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_last;  // counter sits on the last entry
    logic hit;         // entry just read matches the query
    logic miss_last;   // last entry read and no match
    logic res_free;    // result register can take a new result
  } sts_t;

endpackage

[hw/rtl/fmis_ctrl.sv]
// Controller state machine: sequences clear sweeps, loads, scans and result hand-off.
module fmis_ctrl
  import fmis_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic [OP_W-1:0] req_op,
  output logic            req_ready,
  input  sts_t            sts,
  output cmd_t            cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_PUSH
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;

  // Decode commands
  always_comb begin
    cmd            = '0;
    cmd.start      = accept && ((req_op == OP_CLEAR) || (req_op == OP_QUERY));
    cmd.load       = accept && (req_op == OP_LOAD);
    cmd.clear_step = (state == ST_CLEAR);
    cmd.scan_step  = (state == ST_SCAN);
    cmd.capture    = (state == ST_SCAN) && sts.hit;
    cmd.push       = (state == ST_PUSH) && sts.res_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (req_op == OP_CLEAR)) begin
          state_next = ST_CLEAR;
        end else if (accept && (req_op == OP_QUERY)) begin
          state_next = ST_SCAN;
        end
      end
      ST_CLEAR: begin
        if (sts.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (sts.hit) begin
          state_next = ST_PUSH;
        end else if (sts.miss_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_PUSH: begin
        if (sts.res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold state; reset starts with a sweep that invalidates the table
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hw/rtl/fmis_datapath.sv]
// Datapath: entry memory, scan counters, compare and result register.
module fmis_datapath
  import fmis_pkg::*;
#(
  parameter int LISTS          = 4,
  parameter int NODES_PER_LIST = 256
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int DEPTH = LISTS * NODES_PER_LIST;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = (LISTS > 1) ? $clog2(LISTS) : 1;
  localparam int PW    = (NODES_PER_LIST > 1) ? $clog2(NODES_PER_LIST) : 1;

  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [PW-1:0] LAST_POS  = PW'(NODES_PER_LIST - 1);

  // Entry memory: {valid, node index}
  logic [WORD_W-1:0] mem [DEPTH];

  // Query request
  logic [LIST_W-1:0]  q_list;
  logic [POS_W-1:0]   q_pos;
  logic [INDEX_W-1:0] q_idx;

  // Address counter with list/position shadow
  logic [AW-1:0] addr;
  logic [LW-1:0] scan_list;
  logic [PW-1:0] scan_pos;
  logic          issue_open;
  logic          issue;

  // Read stage
  logic [WORD_W-1:0] rd_word;
  logic              rd_pending;
  logic              rd_last;
  logic [LW-1:0]     rd_list;
  logic [PW-1:0]     rd_pos;

  // Match coordinates
  logic [LIST_W-1:0] m_list;
  logic [POS_W-1:0]  m_pos;

  // Write port
  logic              we;
  logic [AW-1:0]     wa;
  logic [WORD_W-1:0] wd;
  logic              ld_in_range;
  logic [AW-1:0]     ld_addr;

  assign issue = cmd.scan_step && issue_open;

  assign ld_in_range = (32'(req.list_number) < LISTS) &&
                       (32'(req.list_position) < NODES_PER_LIST);
  assign ld_addr = AW'(32'(req.list_number) * 32'(NODES_PER_LIST) +
                       32'(req.list_position));

  // Select write source: clear sweep or single load
  always_comb begin
    we = 1'b0;
    wa = addr;
    wd = '0;
    if (cmd.clear_step) begin
      we = 1'b1;
    end else if (cmd.load && ld_in_range) begin
      we = 1'b1;
      wa = ld_addr;
      wd = {1'b1, req.node_index};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_word <= mem[addr];
      rd_last <= (addr == LAST_ADDR);
      rd_list <= scan_list;
      rd_pos  <= scan_pos;
    end
  end

  // Advance counters
  always_ff @(posedge clk) begin
    if (rst) begin
      addr       <= '0;
      scan_list  <= '0;
      scan_pos   <= '0;
      issue_open <= 1'b0;
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= issue;
      if (cmd.start) begin
        addr       <= '0;
        scan_list  <= '0;
        scan_pos   <= '0;
        issue_open <= 1'b1;
        rd_pending <= 1'b0;
      end else if (cmd.clear_step || issue) begin
        addr <= addr + 1'b1;
        if (scan_pos == LAST_POS) begin
          scan_pos  <= '0;
          scan_list <= scan_list + 1'b1;
        end else begin
          scan_pos <= scan_pos + 1'b1;
        end
        if (issue && (addr == LAST_ADDR)) begin
          issue_open <= 1'b0;
        end
      end
    end
  end

  // Latch query fields
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_list <= req.list_number;
      q_pos  <= req.list_position;
      q_idx  <= req.node_index;
    end
  end

  // Latch match coordinates, masked to the result field widths
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      m_list <= LIST_W'(rd_list);
      m_pos  <= POS_W'(rd_pos);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.push) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      res.recv_list     <= q_list;
      res.recv_position <= q_pos;
      res.send_list     <= m_list;
      res.send_position <= m_pos;
    end
  end

  // Status
  always_comb begin
    sts            = '0;
    sts.sweep_last = (addr == LAST_ADDR);
    sts.hit        = rd_pending && rd_word[WORD_W-1] && (rd_word[INDEX_W-1:0] == q_idx);
    sts.miss_last  = rd_pending && rd_last && !sts.hit;
    sts.res_free   = !res_valid || res_ready;
  end

endmodule

[hw/rtl/first_match_index_search_core.sv]
// Top level of the first-match index search: controller plus datapath.
//
// A table of LISTS x NODES_PER_LIST node indices is held in a single-port-read,
// single-port-write memory with a valid flag in each word. A clear request
// sweeps the memory one entry per cycle; the same sweep runs after reset,
// during which no request is taken. A load request leaves the block ready for
// the next request. A query reads one entry per cycle in list-then-position
// order through the memory's registered read port and stops at the first
// match: a hit is then handed off to the result register, and a miss ends
// once the last entry has been read. A query that hits yields one result; all
// other requests yield none. Loads outside the table are dropped. One request
// is worked on at a time.
module first_match_index_search_core
  import fmis_pkg::*;
#(
  parameter int LISTS          = 4,
  parameter int NODES_PER_LIST = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  cmd_t cmd;
  sts_t sts;

  fmis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_op    (req.operation),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fmis_datapath #(
    .LISTS          (LISTS),
    .NODES_PER_LIST (NODES_PER_LIST)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

[hw/rtl/fmis_checker.sv]
// Port-level checker for the first-match index search, bound to the top level.
module fmis_checker
  import fmis_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic res_valid,
  input logic res_ready,
  input res_t res
);

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  // Hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled result changed");

  // Load and unused requests leave the block ready for the next request
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready &&
    ((req.operation == OP_LOAD) || (req.operation == OP_UNUSED)) |=> req_ready)
    else $error("not ready after load request");

  // Clear and query requests occupy the block
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready &&
    ((req.operation == OP_CLEAR) || (req.operation == OP_QUERY)) |=> !req_ready)
    else $error("ready right after clear or query request");

endmodule

bind first_match_index_search_core fmis_checker u_fmis_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

[tb/match_scoreboard_pkg.sv]
// Scoreboard for the first-match index search: table predictor and pending-match store.
`timescale 1ns / 1ps

package match_scoreboard_pkg;
  import fmis_pkg::*;

  localparam int TB_LISTS     = 4;
  localparam int TB_POSITIONS = 256;
  localparam int TB_DEPTH     = TB_LISTS * TB_POSITIONS;

  class match_scoreboard;
    // Shadow copy of the send table
    bit [INDEX_W-1:0] stored_index [TB_DEPTH];
    bit               entry_live   [TB_DEPTH];
    res_t             pending_matches [$];
    int unsigned      mismatch_count;
    int unsigned      predicted_hits;

    function new();
      foreach (entry_live[i]) entry_live[i] = 1'b0;
      mismatch_count = 0;
      predicted_hits = 0;
    endfunction

    // Apply one accepted request to the shadow table; queue a match on a query hit
    function void note_request(req_t r);
      int   slot;
      res_t found;
      case (r.operation)
        OP_CLEAR: begin
          foreach (entry_live[i]) entry_live[i] = 1'b0;
        end
        OP_LOAD: begin
          if (int'(r.list_number) < TB_LISTS && int'(r.list_position) < TB_POSITIONS) begin
            slot = int'(r.list_number) * TB_POSITIONS + int'(r.list_position);
            stored_index[slot] = r.node_index;
            entry_live[slot]   = 1'b1;
          end
        end
        OP_QUERY: begin
          // Flat slot order is list first, then position
          for (int s = 0; s < TB_DEPTH; s++) begin
            if (entry_live[s] && stored_index[s] == r.node_index) begin
              found.recv_list     = r.list_number;
              found.recv_position = r.list_position;
              found.send_list     = LIST_W'(s / TB_POSITIONS);
              found.send_position = POS_W'(s % TB_POSITIONS);
              pending_matches.push_back(found);
              predicted_hits++;
              break;
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      mismatch_count++;
    endtask

    // Compare one accepted result against the oldest pending match
    task check_result(res_t got);
      res_t want;
      if (pending_matches.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", got));
      end else begin
        want = pending_matches.pop_front();
        if (got.recv_list !== want.recv_list)
          report_mismatch($sformatf("recv_list got %0d want %0d",
                                    got.recv_list, want.recv_list));
        if (got.recv_position !== want.recv_position)
          report_mismatch($sformatf("recv_position got %0d want %0d",
                                    got.recv_position, want.recv_position));
        if (got.send_list !== want.send_list)
          report_mismatch($sformatf("send_list got %0d want %0d",
                                    got.send_list, want.send_list));
        if (got.send_position !== want.send_position)
          report_mismatch($sformatf("send_position got %0d want %0d",
                                    got.send_position, want.send_position));
      end
    endtask
  endclass

endpackage

[tb/tb_first_match_index_search_core.sv]
// Testbench top for the first-match index search core: stimulus, handshakes and checking.
`timescale 1ns / 1ps

module tb_first_match_index_search_core;
  import fmis_pkg::*;
  import match_scoreboard_pkg::*;

  localparam int          RANDOM_ITEMS = 550;
  localparam int          RANDOM_CAP   = 2000;
  localparam int unsigned HIT_TARGET   = 40;
  localparam int          DRAIN_CYCLES = TB_DEPTH + 16;
  localparam int unsigned CYCLE_LIMIT  = 4000000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic res_valid;
  logic res_ready;
  res_t res;

  bit              steady;
  int unsigned     cycle_count;
  match_scoreboard sb;

  first_match_index_search_core #(
    .LISTS          (TB_LISTS),
    .NODES_PER_LIST (TB_POSITIONS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always #5 clk = ~clk;

  // Stall the result side at random, except during the steady stretch
  always @(negedge clk) begin
    res_ready <= steady ? 1'b1 : ($urandom_range(99) >= 11);
  end

  // Check results first, then note the request accepted at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && res_ready) sb.check_result(res);
      if (req_valid && req_ready) sb.note_request(req);
    end
  end

  // Abort a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic req_t make_request(logic [OP_W-1:0] op, logic [LIST_W-1:0] lst,
                                        logic [POS_W-1:0] pos, logic [INDEX_W-1:0] idx);
    req_t r;
    r.operation     = op;
    r.list_number   = lst;
    r.list_position = pos;
    r.node_index    = idx;
    return r;
  endfunction

  // Present one request and hold it until accepted
  task automatic send_request(input req_t r);
    @(negedge clk);
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  // Drop valid for a random number of cycles, except during the steady stretch
  task automatic pause_sender();
    if (!steady) begin
      while ($urandom_range(99) < 11) begin
        @(negedge clk);
        req_valid <= 1'b0;
      end
    end
  endtask

  initial begin
    req_t                directed [$];
    req_t                r;
    logic [INDEX_W-1:0]  idx;
    logic [INDEX_W-1:0]  loaded_pool [$];
    int                  sent;
    int unsigned         roll;

    clk       = 1'b0;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    res_ready = 1'b0;
    steady    = 1'b0;
    sb        = new();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, extreme fields, first-match ordering, overwrite, clear, unused op
    directed.push_back(make_request(OP_QUERY, 2'd0, 8'd0, '0));
    directed.push_back(make_request(OP_LOAD, 2'd0, 8'd0, '1));
    directed.push_back(make_request(OP_LOAD, 2'd3, 8'd255, '0));
    directed.push_back(make_request(OP_LOAD, 2'd2, 8'd128, '1));
    directed.push_back(make_request(OP_QUERY, 2'd3, 8'd255, '1));
    directed.push_back(make_request(OP_QUERY, 2'd0, 8'd0, '0));
    directed.push_back(make_request(OP_UNUSED, 2'd3, 8'd255, '1));
    directed.push_back(make_request(OP_LOAD, 2'd1, 8'd7, 31'h2AAA_AAAA));
    directed.push_back(make_request(OP_LOAD, 2'd1, 8'd3, 31'h2AAA_AAAA));
    directed.push_back(make_request(OP_QUERY, 2'd2, 8'd170, 31'h2AAA_AAAA));
    directed.push_back(make_request(OP_QUERY, 2'd1, 8'd85, 31'h5555_5555));
    directed.push_back(make_request(OP_LOAD, 2'd0, 8'd0, 31'd5));
    directed.push_back(make_request(OP_QUERY, 2'd1, 8'd1, '1));
    directed.push_back(make_request(OP_QUERY, 2'd1, 8'd2, 31'd5));
    directed.push_back(make_request(OP_CLEAR, 2'd3, 8'd255, '1));
    directed.push_back(make_request(OP_QUERY, 2'd0, 8'd0, '0));
    directed.push_back(make_request(OP_QUERY, 2'd3, 8'd255, '1));
    directed.push_back(make_request(OP_LOAD, 2'd3, 8'd255, 31'h1234_5678));
    directed.push_back(make_request(OP_QUERY, 2'd2, 8'd9, 31'h1234_5678));
    directed.push_back(make_request(OP_UNUSED, 2'd0, 8'd0, '0));
    directed.push_back(make_request(OP_QUERY, 2'd3, 8'd254, 31'h1234_5678));
    foreach (directed[i]) begin
      pause_sender();
      send_request(directed[i]);
    end

    // Random: mostly loads and queries that reuse loaded indices, some clears and noise
    sent = 0;
    while ((sent < RANDOM_ITEMS || sb.predicted_hits < HIT_TARGET) && sent < RANDOM_CAP) begin
      steady = (sent >= 150 && sent < 300);
      roll   = $urandom_range(99);
      if (roll < 3) begin
        r = make_request(OP_CLEAR, LIST_W'($urandom), POS_W'($urandom), INDEX_W'($urandom));
        loaded_pool.delete();
      end else if (roll < 5) begin
        r = make_request(OP_UNUSED, LIST_W'($urandom), POS_W'($urandom), INDEX_W'($urandom));
      end else if (roll < 55) begin
        // Small values repeat often, so several entries share an index
        idx = ($urandom_range(99) < 40) ? INDEX_W'($urandom_range(15)) : INDEX_W'($urandom);
        r = make_request(OP_LOAD, LIST_W'($urandom), POS_W'($urandom), idx);
        loaded_pool.push_back(idx);
        if (loaded_pool.size() > 48) void'(loaded_pool.pop_front());
      end else begin
        if (loaded_pool.size() > 0 && $urandom_range(99) < 70)
          idx = loaded_pool[$urandom_range(loaded_pool.size() - 1)];
        else
          idx = INDEX_W'($urandom);
        r = make_request(OP_QUERY, LIST_W'($urandom), POS_W'($urandom), idx);
      end
      pause_sender();
      send_request(r);
      if (r.operation != OP_UNUSED) sent++;
    end
    steady = 1'b0;

    @(negedge clk);
    req_valid <= 1'b0;

    // Drain outstanding matches, then let a full miss scan finish
    while (sb.pending_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[first_match_index_search_core.f]
hw/rtl/fmis_pkg.sv
hw/rtl/fmis_ctrl.sv
hw/rtl/fmis_datapath.sv
hw/rtl/first_match_index_search_core.sv
hw/rtl/fmis_checker.sv
tb/match_scoreboard_pkg.sv
tb/tb_first_match_index_search_core.sv
